/* rtl/vn2o_pkg.sv */
// Shared constants, types and tables for the 2-D fractal value noise block.
// Holds the permutation table, the per-octave-count reciprocals and all field widths.
// Depends on nothing; every other file takes names from here by scope.
package vn2o_pkg;

	localparam int unsigned MAX_OCTAVES = 8;
	localparam int unsigned TABLE_SIZE  = 256;

	localparam int unsigned COORD_W    = 24;
	localparam int unsigned FREQ_W     = 24;
	localparam int unsigned SEED_W     = 8;
	localparam int unsigned OCTCNT_W   = 4;
	localparam int unsigned NOISE_W    = 16;
	localparam int unsigned SCALED_W   = 32;
	localparam int unsigned LAT_W      = 8;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned OCT_VAL_W  = 24;
	localparam int unsigned NORM_SHIFT = 8;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [SEED_W-1:0]   SEED_RESET   = 8'd5;
	localparam logic [FREQ_W-1:0]   FREQ_RESET   = 24'd6554;
	localparam logic [OCTCNT_W-1:0] OCTCNT_RESET = 4'd4;

	// 3.0 in Q2.16, the constant term of the smoothstep polynomial
	localparam logic [FRAC_W+1:0] FADE_THREE = 18'd196608;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEED         = 2'd0,
		REG_FREQUENCY    = 2'd1,
		REG_OCTAVE_COUNT = 2'd2
	} cfg_reg_t;

	// floor((2^32 - 1) / (2^d - 1)) for d = 0 .. 16; d = 0 is never used
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned RECIP_W     = 32;
	localparam int unsigned RECIP_DEPTH = 17;
	localparam int unsigned RIDX_W      = 5;
	localparam logic [RECIP_W-1:0] RECIP [RECIP_DEPTH] = '{
		32'h00000000, 32'hFFFFFFFF, 32'h55555555, 32'h24924924,
		32'h11111111, 32'h08421084, 32'h04104104, 32'h02040810,
		32'h01010101, 32'h00804020, 32'h00401004, 32'h00200400,
		32'h00100100, 32'h00080040, 32'h00040010, 32'h00020004,
		32'h00010001
	};

	localparam logic [LAT_W-1:0] PERM [TABLE_SIZE] = '{
		8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
		8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
		8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
		8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
		8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
		8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
		8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
		8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
		8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
		8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
		8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
		8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
		8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
		8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
		8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
		8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
		8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
		8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
		8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
		8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
		8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
		8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
		8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
		8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
		8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
		8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
		8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
		8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
		8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
		8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
		8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
		8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
	};

endpackage

/* rtl/vn2o_if.sv */
// Channel interfaces of the value noise block: coordinate input, noise output
// and configuration write. Depends on vn2o_pkg for the payload widths.
interface vn2o_in_if;
	logic                          valid;
	logic                          ready;
	logic [vn2o_pkg::COORD_W-1:0]  x_coord;
	logic [vn2o_pkg::COORD_W-1:0]  y_coord;
	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface vn2o_out_if;
	logic                          valid;
	logic                          ready;
	logic [vn2o_pkg::NOISE_W-1:0]  noise_value;
	modport source (output valid, output noise_value, input ready);
	modport sink   (input valid, input noise_value, output ready);
endinterface

interface vn2o_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [vn2o_pkg::CFG_IDX_W-1:0]  index;
	logic [vn2o_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/vn2o_octave.sv */
// One octave of value noise: lattice hash, smoothstep weights and bilinear blend.
// Four register stages; depends on vn2o_pkg for the permutation table and widths.
module vn2o_octave #(
	parameter int unsigned OCT = 0
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [vn2o_pkg::SEED_W-1:0]     seed,
	input  logic [vn2o_pkg::SCALED_W-1:0]   xs,
	input  logic [vn2o_pkg::SCALED_W-1:0]   ys,
	output logic [vn2o_pkg::OCT_VAL_W-1:0]  n
);

	localparam int unsigned LW = vn2o_pkg::LAT_W;
	localparam int unsigned FW = vn2o_pkg::FRAC_W;
	localparam int unsigned VW = vn2o_pkg::OCT_VAL_W;
	localparam int unsigned SW = vn2o_pkg::SCALED_W;

	logic [SW-1:0] cx, cy;
	logic [LW-1:0] xi, yi, ty0, ty1;
	logic [FW-1:0] fx, fy;

	logic [FW-1:0]   fx_s1, fy_s1;
	logic [2*FW-1:0] fxx_s1, fyy_s1;
	logic [LW-1:0]   xi_s1, t0_s1, t1_s1;

	logic [FW+1:0]   tx, ty;
	logic [2*FW+1:0] wxp, wyp;
	logic [LW-1:0]   xa0, xa1, xb0, xb1;

	logic [FW-1:0] wx_s2, wy_s2;
	logic [LW-1:0] c00_s2, c10_s2, c01_s2, c11_s2;

	logic [FW:0]   iwx, iwy;
	logic [VW:0]   lo_sum, hi_sum;
	logic [VW-1:0] lo_s3, hi_s3;
	logic [FW-1:0] wy_s3;

	logic [VW+FW:0] blend;
	logic [VW-1:0]  n_s4;

	// octave k sees the coordinates doubled k times
	assign cx  = xs << OCT;
	assign cy  = ys << OCT;
	assign xi  = cx[SW-1 -: LW];
	assign yi  = cy[SW-1 -: LW];
	assign fx  = cx[SW-LW-1 -: FW];
	assign fy  = cy[SW-LW-1 -: FW];
	assign ty0 = yi + seed;
	assign ty1 = ty0 + LW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1  <= fx;
			fy_s1  <= fy;
			fxx_s1 <= (2*FW)'(fx) * (2*FW)'(fx);
			fyy_s1 <= (2*FW)'(fy) * (2*FW)'(fy);
			xi_s1  <= xi;
			t0_s1  <= vn2o_pkg::PERM[ty0];
			t1_s1  <= vn2o_pkg::PERM[ty1];
		end
	end

	// smoothstep: f^2 * (3 - 2f), both products truncated
	assign tx  = vn2o_pkg::FADE_THREE - {1'b0, fx_s1, 1'b0};
	assign ty  = vn2o_pkg::FADE_THREE - {1'b0, fy_s1, 1'b0};
	assign wxp = (2*FW+2)'(fxx_s1[2*FW-1 -: FW]) * (2*FW+2)'(tx);
	assign wyp = (2*FW+2)'(fyy_s1[2*FW-1 -: FW]) * (2*FW+2)'(ty);
	assign xa0 = t0_s1 + xi_s1;
	assign xa1 = xa0 + LW'(1);
	assign xb0 = t1_s1 + xi_s1;
	assign xb1 = xb0 + LW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s2  <= wxp[2*FW-1 -: FW];
			wy_s2  <= wyp[2*FW-1 -: FW];
			c00_s2 <= vn2o_pkg::PERM[xa0];
			c10_s2 <= vn2o_pkg::PERM[xa1];
			c01_s2 <= vn2o_pkg::PERM[xb0];
			c11_s2 <= vn2o_pkg::PERM[xb1];
		end
	end

	// blend along x, exact in Q8.16
	assign iwx    = {1'b1, {FW{1'b0}}} - {1'b0, wx_s2};
	assign lo_sum = (VW+1)'(c00_s2) * (VW+1)'(iwx) + (VW+1)'(c10_s2) * (VW+1)'(wx_s2);
	assign hi_sum = (VW+1)'(c01_s2) * (VW+1)'(iwx) + (VW+1)'(c11_s2) * (VW+1)'(wx_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3 <= lo_sum[VW-1:0];
			hi_s3 <= hi_sum[VW-1:0];
			wy_s3 <= wy_s2;
		end
	end

	// blend along y, truncate back to Q8.16
	assign iwy   = {1'b1, {FW{1'b0}}} - {1'b0, wy_s3};
	assign blend = (VW+FW+1)'(lo_s3) * (VW+FW+1)'(iwy)
		+ (VW+FW+1)'(hi_s3) * (VW+FW+1)'(wy_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s4 <= blend[VW+FW-1 -: VW];
		end
	end

	assign n = n_s4;

endmodule

/* rtl/vn2o_sum.sv */
// Weighted octave sum: one shift-and-add stage per octave (Horner form).
// Depends on vn2o_pkg for the octave value width.
module vn2o_sum #(
	parameter  int unsigned MAX_OCT = vn2o_pkg::MAX_OCTAVES,
	localparam int unsigned DW      = $clog2(MAX_OCT + 1),
	localparam int unsigned VW      = vn2o_pkg::OCT_VAL_W,
	localparam int unsigned ACC_W   = VW + MAX_OCT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  logic [MAX_OCT-1:0][VW-1:0]   n_in,
	input  logic [DW-1:0]                d,
	output logic                         vld_out,
	output logic [ACC_W-1:0]             acc_out
);

	logic [ACC_W-1:0]           acc_s [MAX_OCT];
	logic [MAX_OCT-1:0][VW-1:0] nv_s  [MAX_OCT];
	logic                       vld_s [MAX_OCT];

	for (genvar j = 0; j < MAX_OCT; j++) begin : g_stage
		logic [ACC_W-1:0]           acc_prev;
		logic [MAX_OCT-1:0][VW-1:0] nv_prev;
		logic                       vld_prev;

		if (j == 0) begin : g_first
			assign acc_prev = '0;
			assign nv_prev  = n_in;
			assign vld_prev = vld_in;
		end else begin : g_next
			assign acc_prev = acc_s[j-1];
			assign nv_prev  = nv_s[j-1];
			assign vld_prev = vld_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_prev;
			end
		end

		// octaves past the active count leave the sum alone
		always_ff @(posedge clk) begin
			if (en) begin
				nv_s[j]  <= nv_prev;
				acc_s[j] <= (DW'(j) < d)
					? ({acc_prev[ACC_W-2:0], 1'b0} + ACC_W'(nv_prev[j]))
					: acc_prev;
			end
		end
	end

	assign vld_out = vld_s[MAX_OCT-1];
	assign acc_out = acc_s[MAX_OCT-1];

endmodule

/* rtl/vn2o_div.sv */
// Normalizing divide by 256 * (2^d - 1) through a reciprocal and one correction.
// Three register stages; depends on vn2o_pkg for the reciprocal table.
module vn2o_div #(
	parameter  int unsigned MAX_OCT = vn2o_pkg::MAX_OCTAVES,
	localparam int unsigned DW      = $clog2(MAX_OCT + 1),
	localparam int unsigned ACC_W   = vn2o_pkg::OCT_VAL_W + MAX_OCT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [ACC_W-1:0]              acc,
	input  logic [DW-1:0]                 d,
	output logic                          vld_out,
	output logic [vn2o_pkg::NOISE_W-1:0]  q
);

	localparam int unsigned QW = vn2o_pkg::NOISE_W;
	localparam int unsigned AW = ACC_W - vn2o_pkg::NORM_SHIFT;
	localparam int unsigned PW = AW + vn2o_pkg::RECIP_W;

	logic [AW-1:0] a;
	logic [PW-1:0] prod_s1;
	logic [AW-1:0] a_s1, a_s2, qd, r, dm;
	logic [QW-1:0] q_est, q_s2, q_s3;
	logic [AW-1:0] qd_s2;
	logic          fix;
	logic          vld_s1, vld_s2, vld_s3;

	assign a = acc[ACC_W-1:vn2o_pkg::NORM_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// estimate is the true quotient or one below it
	assign q_est = prod_s1[vn2o_pkg::RECIP_SHIFT +: QW];
	assign qd    = (AW'(q_est) << d) - AW'(q_est);
	assign r     = a_s2 - qd_s2;
	assign dm    = (AW'(1) << d) - AW'(1);
	assign fix   = (d != '0) && (r >= dm);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a;
			prod_s1 <= PW'(a) * PW'(vn2o_pkg::RECIP[vn2o_pkg::RIDX_W'(d)]);
			a_s2    <= a_s1;
			q_s2    <= q_est;
			qd_s2   <= qd;
			q_s3    <= (d == '0) ? '0 : q_s2 + QW'(fix);
		end
	end

	assign vld_out = vld_s3;
	assign q       = q_s3;

endmodule

/* rtl/value_noise_2d_octaves.sv */
// Top level of the fractal 2-D value noise generator.
// Depends on vn2o_pkg, vn2o_if, vn2o_octave, vn2o_sum and vn2o_div.
//
// Usage:
//   coord  - input words, one unsigned Q16.8 (x_coord, y_coord) pair each.
//   noise  - output words, one unsigned Q0.16 noise_value per input word, in order.
//   cfg    - register writes (seed, frequency, octave_count); always ready.
//            Write only while no word is in flight.
// Throughput: one word per cycle while the receiver keeps noise.ready high. Every octave has its own lattice
// unit, and the octave sum and divide are fully pipelined.
// Pipeline from accept to noise.valid: 1 scaling multiply, 4 lattice/blend stages,
//   one accumulate stage per octave, 3 divide stages and the output buffer.
// Reset: registers return to seed 5, frequency 6554, octave_count 4; the
//   pipeline and the output buffer empty.
// Stall: a two-word output buffer absorbs results while noise.ready is low;
//   only when it is full and the receiver still stalls does the whole pipeline
//   hold and coord.ready drop. Nothing is lost or repeated.
module value_noise_2d_octaves #(
	parameter int unsigned MAX_OCTAVES = vn2o_pkg::MAX_OCTAVES
) (
	input  logic           clk,
	input  logic           arst_n,
	vn2o_cfg_if.sink       cfg,
	vn2o_in_if.sink        coord,
	vn2o_out_if.source     noise
);

	localparam int unsigned DW    = $clog2(MAX_OCTAVES + 1);
	localparam int unsigned VW    = vn2o_pkg::OCT_VAL_W;
	localparam int unsigned ACC_W = VW + MAX_OCTAVES;
	localparam int unsigned CW    = vn2o_pkg::COORD_W + vn2o_pkg::FREQ_W;
	localparam int unsigned SW    = vn2o_pkg::SCALED_W;
	localparam int unsigned QW    = vn2o_pkg::NOISE_W;

	// configuration registers
	logic [vn2o_pkg::SEED_W-1:0]   seed_q;
	logic [vn2o_pkg::FREQ_W-1:0]   freq_q;
	logic [vn2o_pkg::OCTCNT_W-1:0] octcnt_q;
	logic [DW-1:0]                 oct_eff;

	// pipeline
	logic                         en;
	logic [CW-1:0]                xprod, yprod;
	logic [SW-1:0]                xs_s1, ys_s1;
	logic                         vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [MAX_OCTAVES-1:0][VW-1:0] n_vec;
	logic                         vld_sum;
	logic [ACC_W-1:0]             acc_sum;
	logic                         vld_div;
	logic [QW-1:0]                q_div;

	// output buffer
	logic [QW-1:0] obuf_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          push, pop;

	// ---------------------------------------------------------------- config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= vn2o_pkg::SEED_RESET;
			freq_q   <= vn2o_pkg::FREQ_RESET;
			octcnt_q <= vn2o_pkg::OCTCNT_RESET;
		end else if (cfg.valid) begin
			case (vn2o_pkg::cfg_reg_t'(cfg.index))
				vn2o_pkg::REG_SEED: begin
					seed_q <= cfg.data[vn2o_pkg::SEED_W-1:0];
				end
				vn2o_pkg::REG_FREQUENCY: begin
					freq_q <= cfg.data[vn2o_pkg::FREQ_W-1:0];
				end
				vn2o_pkg::REG_OCTAVE_COUNT: begin
					octcnt_q <= cfg.data[vn2o_pkg::OCTCNT_W-1:0];
				end
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// clamp the octave count to the octaves that are built
	assign oct_eff = ({1'b0, octcnt_q} > (vn2o_pkg::OCTCNT_W+1)'(MAX_OCTAVES))
		? DW'(MAX_OCTAVES) : DW'(octcnt_q);

	// -------------------------------------------------------------- pipeline
	// Advance everything together; hold only when the buffer is full and the
	// receiver is not taking a word this cycle.
	assign en          = (count_q != 2'd2) || noise.ready;
	assign coord.ready = en;

	// scale to Q24.24; only the low 32 bits reach any octave's index or fraction
	assign xprod = CW'(coord.x_coord) * CW'(freq_q);
	assign yprod = CW'(coord.y_coord) * CW'(freq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= coord.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xs_s1 <= xprod[SW-1:0];
			ys_s1 <= yprod[SW-1:0];
		end
	end

	// one lattice unit per octave, all working on the same word
	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
		vn2o_octave #(
			.OCT (k)
		) u_oct (
			.clk  (clk),
			.en   (en),
			.seed (seed_q),
			.xs   (xs_s1),
			.ys   (ys_s1),
			.n    (n_vec[k])
		);
	end

	vn2o_sum #(
		.MAX_OCT (MAX_OCTAVES)
	) u_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s5),
		.n_in    (n_vec),
		.d       (oct_eff),
		.vld_out (vld_sum),
		.acc_out (acc_sum)
	);

	vn2o_div #(
		.MAX_OCT (MAX_OCTAVES)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_sum),
		.acc     (acc_sum),
		.d       (oct_eff),
		.vld_out (vld_div),
		.q       (q_div)
	);

	// --------------------------------------------------------- output buffer
	assign push              = vld_div && en;
	assign pop               = noise.valid && noise.ready;
	assign noise.valid       = (count_q != 2'd0);
	assign noise.noise_value = obuf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			obuf_q[wr_ptr_q] <= q_div;
		end
	end

	// ------------------------------------------------------------ assertions
	// a full buffer facing a stalled receiver keeps its head word
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !noise.ready) |=>
			(count_q == 2'd2 && $stable(noise.noise_value)))
		else $error("output buffer changed while full and stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output buffer count overflow");

	// no word appears without the divider delivering one
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 && !vld_div) |=> !noise.valid)
		else $error("output word without a pipeline result");

endmodule

/* bench/vn2o_noise_check.sv */
// Scoreboard for the fractal value noise block: watches the cfg, coord and noise channels.
// Predicts each noise word from its own register copy and compares it in order.
// Depends on vn2o_pkg (table, widths, register codes) and the channel interfaces in vn2o_if.
module vn2o_noise_check (
	input  logic       clk,
	input  logic       arst_n,
	vn2o_cfg_if        cfg,
	vn2o_in_if         coord,
	vn2o_out_if        noise,
	output int         fails,
	output int         pending,
	output int         checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import vn2o_pkg::*;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [NOISE_W-1:0] noise;
	} noise_due_t;

	noise_due_t         noise_due[$];
	logic [SEED_W-1:0]   seed_copy  = SEED_RESET;
	logic [FREQ_W-1:0]   freq_copy  = FREQ_RESET;
	logic [OCTCNT_W-1:0] octave_copy = OCTCNT_RESET;
	int                  fail_cnt    = 0;
	int                  due_cnt     = 0;
	int                  checked_cnt = 0;

	assign fails   = fail_cnt;
	assign pending = due_cnt;
	assign checked = checked_cnt;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_cnt++;
	endtask

	function automatic logic [63:0] smooth_weight(input logic [FRAC_W-1:0] f);
		logic [63:0] f2;
		logic [63:0] t;
		f2 = (64'(f) * 64'(f)) >> 16;
		t  = 64'd196608 - 64'd2 * 64'(f);
		return (f2 * t) >> 16;
	endfunction

	function automatic logic [LAT_W-1:0] lattice_hash(input logic [LAT_W-1:0] xi,
			input logic [LAT_W-1:0] yi, input logic [SEED_W-1:0] sd);
		logic [LAT_W-1:0] row;
		logic [LAT_W-1:0] col;
		row = yi + sd;
		col = PERM[row] + xi;
		return PERM[col];
	endfunction

	// One octave at Q24.24 coordinates, Q8.16 result.
	function automatic logic [63:0] octave_sample(input logic [63:0] cx, input logic [63:0] cy,
			input logic [SEED_W-1:0] sd);
		logic [LAT_W-1:0] xi, yi, xn, yn;
		logic [63:0] wx, wy, lo, hi;
		xi = cx[31:24];
		yi = cy[31:24];
		xn = xi + 8'd1;
		yn = yi + 8'd1;
		wx = smooth_weight(cx[23:8]);
		wy = smooth_weight(cy[23:8]);
		lo = 64'(lattice_hash(xi, yi, sd)) * (64'd65536 - wx)
			+ 64'(lattice_hash(xn, yi, sd)) * wx;
		hi = 64'(lattice_hash(xi, yn, sd)) * (64'd65536 - wx)
			+ 64'(lattice_hash(xn, yn, sd)) * wx;
		return (lo * (64'd65536 - wy) + hi * wy) >> 16;
	endfunction

	function automatic logic [NOISE_W-1:0] fractal_noise(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [SEED_W-1:0] sd,
			input logic [FREQ_W-1:0] fr, input logic [OCTCNT_W-1:0] oc);
		logic [63:0] xs, ys, acc, den;
		int unsigned d;
		int unsigned k;
		xs = 64'(x) * 64'(fr);
		ys = 64'(y) * 64'(fr);
		d  = oc;
		if (d > MAX_OCTAVES) d = MAX_OCTAVES;
		if (d == 0) return '0;
		acc = '0;
		for (k = 0; k < d; k++) begin
			acc += octave_sample(xs << k, ys << k, sd) << (d - 1 - k);
		end
		den = 64'd256 * ((64'd1 << d) - 64'd1);
		return NOISE_W'(acc / den);
	endfunction

	// Sample at the falling edge: everything is settled and holds until the next rising edge.
	always @(negedge clk) begin
		noise_due_t due;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_SEED:         seed_copy   = cfg.data[SEED_W-1:0];
					REG_FREQUENCY:    freq_copy   = cfg.data[FREQ_W-1:0];
					REG_OCTAVE_COUNT: octave_copy = cfg.data[OCTCNT_W-1:0];
					default: ;
				endcase
			end
			if (coord.valid && coord.ready) begin
				due.x     = coord.x_coord;
				due.y     = coord.y_coord;
				due.noise = fractal_noise(coord.x_coord, coord.y_coord, seed_copy, freq_copy,
					octave_copy);
				noise_due.push_back(due);
				due_cnt++;
			end
			if (noise.valid && noise.ready) begin
				if (noise_due.size() == 0) begin
					report_mismatch($sformatf("noise word %h with nothing outstanding",
						noise.noise_value));
				end else begin
					due = noise_due.pop_front();
					due_cnt--;
					checked_cnt++;
					if (noise.noise_value !== due.noise)
						report_mismatch($sformatf("x=%h y=%h noise_value got %h want %h",
							due.x, due.y, noise.noise_value, due.noise));
				end
			end
		end
	end

endmodule

/* bench/tb_value_noise_2d_octaves.sv */
// Top of the value noise testbench: clock, reset, stimulus, receiver and verdict.
// Instantiates value_noise_2d_octaves and the vn2o_noise_check scoreboard beside it.
// Depends on vn2o_pkg, vn2o_if and bench/vn2o_noise_check.sv.
module tb_value_noise_2d_octaves;
	timeunit 1ns;
	timeprecision 1ps;

	import vn2o_pkg::*;

	// Index 3 maps to no register; writes there must leave the settings alone.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int LATENCY      = MAX_OCTAVES + 9;
	localparam int HOLD_LEN     = 300;   // long receiver hold-off, in cycles
	localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving before giving up
	localparam int RANDOM_ITEMS = 930;
	localparam int FINAL_ITEMS  = 130;   // last stretch, both sides always ready

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	vn2o_cfg_if cfg_ch ();
	vn2o_in_if  coord_ch ();
	vn2o_out_if noise_ch ();

	int fails;
	int outstanding;
	int checked;

	bit hold_req     = 1'b0;  // set by stimulus, cleared by the receiver once it holds
	bit no_idle      = 1'b0;
	int settings_cnt = 0;
	int quiet        = 0;

	value_noise_2d_octaves dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.coord  (coord_ch),
		.noise  (noise_ch)
	);

	vn2o_noise_check u_noise_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.coord   (coord_ch),
		.noise   (noise_ch),
		.fails   (fails),
		.pending (outstanding),
		.checked (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: alternate random ready runs with random stall bursts, take the long
	// hold-off when asked, and stay ready for the whole last stretch.
	initial begin
		int  run;
		logic rdy;
		run = 0;
		rdy = 1'b0;
		noise_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				noise_ch.ready <= 1'b0;
				repeat (HOLD_LEN - 1) @(posedge clk);
				run = 0;
			end else begin
				if (no_idle) begin
					rdy = 1'b1;
				end else if (run == 0) begin
					if (rdy) begin
						rdy = 1'b0;
						run = $urandom_range(1, 9);
					end else begin
						rdy = 1'b1;
						run = $urandom_range(1, 40);
					end
				end
				if (run > 0) run--;
				noise_ch.ready <= rdy;
			end
		end
	end

	// Watchdog: count cycles in which no word moves on any channel.
	always @(negedge clk) begin
		if (arst_n) begin
			if ((coord_ch.valid && coord_ch.ready) || (noise_ch.valid && noise_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles, %0d noise words outstanding",
					quiet, outstanding);
				$display("FAIL");
				$finish;
			end
		end
	end

	// Offer one coordinate word and return at the edge that accepts it. Valid stays high
	// on return so back-to-back words need no second assignment in the same step.
	task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		int gap;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			coord_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coord_ch.valid   <= 1'b1;
		coord_ch.x_coord <= x;
		coord_ch.y_coord <= y;
		do @(negedge clk); while (!coord_ch.ready);
		@(posedge clk);
	endtask

	// Drop valid and hold until every predicted noise word has come back.
	task automatic drain();
		coord_ch.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= word;
		do @(negedge clk); while (!cfg_ch.ready);
		@(posedge clk);
	endtask

	// Write all three registers plus a stray write to the unused index. Upper data bits
	// beyond the seed and octave count widths are random and must be dropped by the block.
	task automatic set_regs(input logic [SEED_W-1:0] sd, input logic [FREQ_W-1:0] fr,
			input logic [OCTCNT_W-1:0] oc);
		push_reg(REG_SEED, {16'($urandom), sd});
		push_reg(REG_FREQUENCY, fr);
		push_reg(REG_OCTAVE_COUNT, {20'($urandom), oc});
		push_reg(REG_UNUSED, 24'($urandom));
		cfg_ch.valid <= 1'b0;
		settings_cnt++;
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return COORD_W'($urandom_range(0, 1023));
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return FREQ_W'($urandom_range(1, 255));
			default: return FREQ_W'($urandom) >> $urandom_range(0, 16);
		endcase
	endfunction

	function automatic logic [OCTCNT_W-1:0] pick_octaves();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return OCTCNT_W'($urandom_range(MAX_OCTAVES + 1, 15));
			default: return OCTCNT_W'($urandom_range(1, MAX_OCTAVES));
		endcase
	endfunction

	initial begin
		int n;
		int sent_random;
		int phase;
		coord_ch.valid   = 1'b0;
		coord_ch.x_coord = '0;
		coord_ch.y_coord = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings untouched: seed 5, frequency 6554, four octaves.
		send_coord('0, '0);
		send_coord('1, '1);
		send_coord(24'h000100, 24'h000080);
		send_coord(24'h123456, 24'h654321);
		drain();

		// Zero frequency: every sample lands on the origin cell, single octave.
		set_regs(8'd0, '0, 4'd1);
		send_coord('1, '0);
		send_coord(24'h001234, 24'h005678);
		drain();

		// Full-scale frequency and seed, all octaves; lattice index wraps.
		set_regs(8'hFF, '1, 4'(MAX_OCTAVES));
		send_coord('1, '1);
		send_coord('0, '0);
		send_coord(24'h000001, 24'hFFFFFE);
		send_coord(24'h800000, 24'h7FFFFF);
		drain();

		// Zero octaves: result is zero whatever the coordinates.
		set_regs(8'd17, 24'h010000, 4'd0);
		send_coord(24'h012345, 24'h00ABCD);
		send_coord('1, '1);
		drain();

		// Octave count beyond the maximum saturates.
		set_regs(8'd200, 24'h010000, 4'd15);
		send_coord(24'h00FF80, 24'h000040);
		send_coord(pick_coord(), pick_coord());
		drain();

		set_regs(8'd1, 24'h028000, 4'(MAX_OCTAVES + 1));
		send_coord(24'h00FFFF, 24'h00FF00);
		send_coord(pick_coord(), pick_coord());
		drain();

		// Smallest nonzero frequency.
		set_regs(8'd128, 24'h000001, 4'd2);
		send_coord('1, 24'h000001);
		send_coord(pick_coord(), pick_coord());
		drain();

		// Random phases, each under fresh register values. One phase starts with the
		// long receiver hold-off so the pipeline backs up and coord.ready drops.
		sent_random = 0;
		phase = 0;
		while (sent_random < RANDOM_ITEMS - FINAL_ITEMS) begin
			set_regs(SEED_W'($urandom), pick_freq(), pick_octaves());
			if (phase == 2) hold_req = 1'b1;
			n = $urandom_range(40, 80);
			repeat (n) send_coord(pick_coord(), pick_coord());
			sent_random += n;
			drain();
			phase++;
		end

		// Last stretch at full rate with no idling on either side.
		no_idle = 1'b1;
		set_regs(SEED_W'($urandom), FREQ_W'($urandom), 4'(MAX_OCTAVES));
		repeat (FINAL_ITEMS) send_coord(pick_coord(), pick_coord());
		drain();
		repeat (2 * LATENCY) @(posedge clk);

		$display("checked %0d noise words over %0d register settings, octave counts 0 to 15,",
			checked, settings_cnt);
		$display("frequency from zero to full scale, with a %0d-cycle output hold-off", HOLD_LEN);
		if (outstanding != 0)
			$display("%0d noise words never arrived", outstanding);
		if (fails == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
